@@ design/c128b_pkg.sv @@
// ----------------------------------------------------------------------------
// c128b_pkg
// Shared types, constants and the bar pattern table of the Code 128 set B
// symbol encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package c128b_pkg;

   // Symbol values and checksum modulus
   localparam logic [6:0] SYM_START  = 7'd104;
   localparam logic [6:0] SYM_STOP   = 7'd106;
   localparam logic [6:0] CHK_MOD    = 7'd103;

   // Accepted byte range and the substitute for bytes outside it
   localparam logic [7:0] BYTE_LOW   = 8'd32;
   localparam logic [7:0] BYTE_SUBST = 8'd63;

   // 128 mod 103: weight of the upper part when folding a value by 7 bits
   localparam logic [4:0] FOLD_FACTOR = 5'd25;

   // Position after which the weight wraps to zero
   localparam logic [6:0] POS_LAST = 7'd102;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Input beat
   typedef struct packed {
      logic [7:0] char_byte;
      logic       has_char;
      logic       end_of_message;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [6:0] symbol_value;
      logic [2:0] width_one;
      logic [2:0] width_two;
      logic [2:0] width_three;
      logic [2:0] width_four;
      logic [2:0] width_five;
      logic [2:0] width_six;
      logic [1:0] width_seven;
      logic       run_done;
      logic       message_done;
   } rsp_type;

   // What one accepted item asks the back end to emit
   typedef struct packed {
      logic start;   // emit the start symbol first
      logic data;    // emit a data symbol
      logic close;   // emit checksum and stop
   } kind_type;

   // Queue entry between front and back
   typedef struct packed {
      kind_type   kind;
      logic [6:0] data_sym;
      logic [6:0] chk_sym;
   } job_type;

   // Six module widths per symbol, one hex digit each, first bar leftmost.
   // The stop symbol carries a seventh bar of width 2, added separately.
   localparam logic [23:0] BAR_TABLE [0:106] = '{
      24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322,
      24'h131222, 24'h122213, 24'h122312, 24'h132212, 24'h221213,
      24'h221312, 24'h231212, 24'h112232, 24'h122132, 24'h122231,
      24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132,
      24'h221231, 24'h213212, 24'h223112, 24'h312131, 24'h311222,
      24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
      24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
      24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313,
      24'h231113, 24'h231311, 24'h112133, 24'h112331, 24'h132131,
      24'h113123, 24'h113321, 24'h133121, 24'h313121, 24'h211331,
      24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123,
      24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
      24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422,
      24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
      24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211,
      24'h241211, 24'h221114, 24'h413111, 24'h241112, 24'h134111,
      24'h111242, 24'h121142, 24'h121241, 24'h114212, 24'h124112,
      24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
      24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141,
      24'h114113, 24'h114311, 24'h411113, 24'h411311, 24'h113141,
      24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
      24'h211232, 24'h233111
   };

endpackage

`default_nettype wire

@@ design/code128b_symbol_encoder_top.sv @@
// ----------------------------------------------------------------------------
// code128b_symbol_encoder_top
// Code 128 set B encoder: message bytes in, symbols with bar widths out.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                            | Beat
//   --------+----------------------------------+------------------------------
//   request | req_valid, req_stall, req_data   | one message byte and flags
//   result  | rsp_valid, rsp_stall, rsp_data   | one symbol with its widths
//
// A byte that yields one symbol is taken every cycle while req_stall is low;
// an item yielding n symbols (1 to 4) holds the expander until all are out,
// one symbol per cycle unless rsp_stall holds the back end. Beats pass four
// front stages (classify, multiply, two modulo folds), the queue, the job
// register and the output register. Reset is synchronous and clears all
// control state; no clearing pass is needed. req_stall rises only when the
// queue is full with a job waiting at the front's last stage, so the two
// sides stall apart.
`default_nettype none

module code128b_symbol_encoder_top #(
   parameter int QUEUE_DEPTH = c128b_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire c128b_pkg::req_type  req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output c128b_pkg::rsp_type       rsp_data
);
   import c128b_pkg::*;

   // Front to queue
   logic    push_valid;
   job_type push_job;
   logic    queue_full;

   // Queue to back
   logic    job_valid;
   job_type head_job;
   logic    pop;

   // Classify bytes, track position and fold the weighted checksum
   c128b_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   // Hold jobs so the byte side keeps flowing while symbols drain
   c128b_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .not_empty  (job_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   // Expand each job into start, data, checksum and stop beats
   c128b_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ design/c128b_front.sv @@
// ----------------------------------------------------------------------------
// c128b_front
// Accepts message bytes, classifies them and carries the weighted checksum
// through a four-stage pipeline into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module c128b_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire c128b_pkg::req_type  req_data,
   output logic                     push_valid,
   output c128b_pkg::job_type       push_job,
   input  wire logic                queue_full
);
   import c128b_pkg::*;

   logic       adv;
   logic       take;
   logic       real_item;
   logic       start_now;
   logic [6:0] d_now;
   logic [6:0] pos_use;
   logic [6:0] pos_next;

   logic       inside_ff, inside_in;
   logic [6:0] pos_ff, pos_in;
   logic [6:0] acc_ff, acc_in;

   logic       s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   kind_type   s1_kind_ff, s2_kind_ff, s3_kind_ff, s4_kind_ff;
   logic [6:0] s1_d_ff, s2_d_ff, s3_d_ff, s4_d_ff;
   logic [6:0] s1_pos_ff;
   logic [13:0] s2_prod_ff, s2_prod_in;
   logic [8:0]  s3_fold_ff, s3_fold_in;
   logic [10:0] fold1;
   logic [7:0]  fold3;
   logic [6:0]  s4_rem_ff, s4_rem_in;

   logic [6:0] base;
   logic [7:0] sum;
   logic [6:0] chk;

   // Advance the whole pipeline unless the last stage is blocked
   assign adv       = !s4_valid_ff || !queue_full;
   assign req_stall = !adv;
   assign take      = req_valid && adv;
   assign real_item = req_data.has_char || req_data.end_of_message;
   assign start_now = !inside_ff;

   always_comb begin
      if (req_data.char_byte < BYTE_LOW || req_data.char_byte[7]) begin
         d_now = 7'(BYTE_SUBST - BYTE_LOW);
      end else begin
         d_now = 7'(req_data.char_byte - BYTE_LOW);
      end
   end

   assign pos_use  = start_now ? 7'd1 : pos_ff;
   assign pos_next = (pos_use == POS_LAST) ? 7'd0 : pos_use + 7'd1;

   always_comb begin
      inside_in = inside_ff;
      pos_in    = pos_ff;
      if (take && real_item) begin
         if (req_data.end_of_message) begin
            inside_in = 1'b0;
            pos_in    = 7'd0;
         end else begin
            inside_in = 1'b1;
            pos_in    = req_data.has_char ? pos_next : pos_use;
         end
      end
   end

   // Reduce the product modulo 103 by folding 7 bits at a time
   assign s2_prod_in = 14'(s1_d_ff) * 14'(s1_pos_ff);
   assign fold1      = 11'(s2_prod_ff[13:7]) * 11'(FOLD_FACTOR) + 11'(s2_prod_ff[6:0]);
   assign s3_fold_in = 9'(fold1[10:7]) * 9'(FOLD_FACTOR) + 9'(fold1[6:0]);
   assign fold3      = 8'(s3_fold_ff[8:7]) * 8'(FOLD_FACTOR) + 8'(s3_fold_ff[6:0]);
   assign s4_rem_in  = (fold3 >= 8'(CHK_MOD)) ? 7'(fold3 - 8'(CHK_MOD)) : fold3[6:0];

   // Accumulate at the queue; start symbol seeds the sum with 104 mod 103
   assign base = s4_kind_ff.start ? 7'(SYM_START - CHK_MOD) : acc_ff;
   assign sum  = 8'(base) + (s4_kind_ff.data ? 8'(s4_rem_ff) : 8'd0);
   assign chk  = (sum >= 8'(CHK_MOD)) ? 7'(sum - 8'(CHK_MOD)) : sum[6:0];

   assign push_valid        = s4_valid_ff && !queue_full;
   assign push_job.kind     = s4_kind_ff;
   assign push_job.data_sym = s4_d_ff;
   assign push_job.chk_sym  = chk;

   always_comb begin
      acc_in = acc_ff;
      if (push_valid) begin
         acc_in = s4_kind_ff.close ? 7'd0 : chk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff   <= 1'b0;
         pos_ff      <= 7'd0;
         acc_ff      <= 7'd0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         inside_ff <= inside_in;
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
         if (adv) begin
            s1_valid_ff <= take && real_item;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff.start <= start_now;
         s1_kind_ff.data  <= req_data.has_char;
         s1_kind_ff.close <= req_data.end_of_message;
         s1_d_ff          <= d_now;
         s1_pos_ff        <= pos_use;
         s2_kind_ff       <= s1_kind_ff;
         s2_d_ff          <= s1_d_ff;
         s2_prod_ff       <= s2_prod_in;
         s3_kind_ff       <= s2_kind_ff;
         s3_d_ff          <= s2_d_ff;
         s3_fold_ff       <= s3_fold_in;
         s4_kind_ff       <= s3_kind_ff;
         s4_d_ff          <= s3_d_ff;
         s4_rem_ff        <= s4_rem_in;
      end
   end

endmodule

`default_nettype wire

@@ design/c128b_queue.sv @@
// ----------------------------------------------------------------------------
// c128b_queue
// Short job queue between the front pipeline and the symbol expander.
// ----------------------------------------------------------------------------
`default_nettype none

module c128b_queue #(
   parameter int DEPTH = c128b_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire c128b_pkg::job_type  push_job,
   output logic                     full,
   output logic                     not_empty,
   output c128b_pkg::job_type       head_job,
   input  wire logic                pop
);
   import c128b_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type       slots_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

@@ design/c128b_back.sv @@
// ----------------------------------------------------------------------------
// c128b_back
// Expands one job into its symbols, one per cycle while not stalled, looks
// up the bar widths and holds each result beat in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module c128b_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                job_valid,
   input  wire c128b_pkg::job_type  job,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output c128b_pkg::rsp_type       rsp_data
);
   import c128b_pkg::*;

   // Pending symbols of the current job: start, data, checksum, stop
   localparam logic [3:0] PICK_START = 4'b0001;
   localparam logic [3:0] PICK_DATA  = 4'b0010;
   localparam logic [3:0] PICK_CHK   = 4'b0100;
   localparam logic [3:0] PICK_STOP  = 4'b1000;

   logic [3:0] pend_ff, pend_in;
   logic [6:0] data_sym_ff;
   logic [6:0] chk_sym_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;

   logic       adv;
   logic       emit;
   logic       last;
   logic [3:0] pick;
   logic [6:0] sym;
   logic [23:0] bars;

   assign adv  = !rsp_valid_ff || !rsp_stall;
   assign pick = pend_ff & (~pend_ff + 4'd1);
   assign last = ((pend_ff & ~pick) == 4'd0);
   assign emit = adv && (pend_ff != 4'd0);
   assign pop  = job_valid && ((pend_ff == 4'd0) || (emit && last));

   always_comb begin
      case (pick)
         PICK_START: sym = SYM_START;
         PICK_DATA:  sym = data_sym_ff;
         PICK_CHK:   sym = chk_sym_ff;
         PICK_STOP:  sym = SYM_STOP;
         default:    sym = SYM_START;
      endcase
   end

   assign bars = BAR_TABLE[sym];

   always_comb begin
      pend_in = pend_ff;
      if (pop) begin
         pend_in = {job.kind.close, job.kind.close, job.kind.data, job.kind.start};
      end else if (emit) begin
         pend_in = pend_ff & ~pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (adv) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_sym_ff <= job.data_sym;
         chk_sym_ff  <= job.chk_sym;
      end
      if (emit) begin
         rsp_data_ff.symbol_value <= sym;
         rsp_data_ff.width_one    <= bars[22:20];
         rsp_data_ff.width_two    <= bars[18:16];
         rsp_data_ff.width_three  <= bars[14:12];
         rsp_data_ff.width_four   <= bars[10:8];
         rsp_data_ff.width_five   <= bars[6:4];
         rsp_data_ff.width_six    <= bars[2:0];
         rsp_data_ff.width_seven  <= (pick == PICK_STOP) ? 2'd2 : 2'd0;
         rsp_data_ff.run_done     <= last;
         rsp_data_ff.message_done <= (pick == PICK_STOP);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
